// ----- rtl/serial_seven_segment_scanner_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SERIAL_SEVEN_SEGMENT_SCANNER_UNIT_DEFINES_SVH
`define SERIAL_SEVEN_SEGMENT_SCANNER_UNIT_DEFINES_SVH

// Clocked property, ignored while reset is high
`define SEVSEG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well
`define SEVSEG_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sevseg_pkg.sv -----
package sevseg_pkg;

  // Request kinds on the input channel
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_SHOW_CHAR    = 2'd0;
  localparam logic [1:0] CFG_VISIBLE_CHAR = 2'd1;
  localparam logic [1:0] CFG_URGENT_CHAR  = 2'd2;
  localparam logic [1:0] CFG_BLINK_TICKS  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_SHOW_CHAR    = 8'd119;
  localparam logic [7:0]  RST_VISIBLE_CHAR = 8'd118;
  localparam logic [7:0]  RST_URGENT_CHAR  = 8'd117;
  localparam logic [15:0] RST_BLINK_TICKS  = 16'd350;

  // ASCII digit range
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Segment bits
  localparam logic [7:0] SEG_DP = 8'h02;

  // Display pattern of a decimal digit
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pattern;
    case (digit)
      4'd0: pattern = 8'hDD;
      4'd1: pattern = 8'h50;
      4'd2: pattern = 8'hEC;
      4'd3: pattern = 8'hF8;
      4'd4: pattern = 8'h71;
      4'd5: pattern = 8'hB9;
      4'd6: pattern = 8'hBD;
      4'd7: pattern = 8'hD0;
      4'd8: pattern = 8'hFD;
      4'd9: pattern = 8'hF9;
      default: pattern = 8'h00;
    endcase
    return pattern;
  endfunction

  // Fold a four-bit digit code into 0..9
  function automatic logic [3:0] digit_mod10(input logic [3:0] digit);
    return (digit >= 4'd10) ? (digit - 4'd10) : digit;
  endfunction

endpackage

// ----- rtl/serial_seven_segment_scanner_unit.sv -----
// Channel   Direction  Handshake          Payload
// in        in         in_valid/in_ready  req_type, rx_byte
// out       out        out_valid/out_ready segment_lines, digit_select_n, lit
// cfg       in         cfg_write          cfg_index, cfg_data
//
// One item per cycle while no tick waits; a transfer loads the input register and,
// as the item leaves it, updates the state and, for a tick, the result register.
// Bytes give no result; a tick waits in the input register only while the
// result register holds an untaken result and out_ready is low.
// Reset (rst, synchronous) sets valid flags, configuration and display state; no clearing pass.
module serial_seven_segment_scanner_unit #(
  parameter int DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  segment_lines,
  output logic [3:0]  digit_select_n,
  output logic        lit,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(DIGITS + 1);
  localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [CW-1:0] DIGITS_CW = CW'(DIGITS);

  // Configuration
  logic [7:0]  cmd_show_char;
  logic [7:0]  cmd_visible_char;
  logic [7:0]  cmd_urgent_char;
  logic [15:0] blink_ticks;

  // Input register
  logic       s1_valid;
  logic       s1_type;
  logic [7:0] s1_byte;
  logic       s1_advance;

  // Display state
  logic [3:0]    shown_digits [DIGITS];
  logic [CW-1:0] shown_count;
  logic [3:0]    pending_digits [DIGITS];
  logic [CW-1:0] pending_count;
  logic [9:0]    pending_mask;
  logic [9:0]    visible_mask;
  logic [9:0]    urgent_mask;
  logic          blink_on;
  logic [15:0]   blink_count;
  logic [IW-1:0] scan_index;

  logic [CW-1:0] shown_count_next;
  logic [CW-1:0] pending_count_next;
  logic [9:0]    pending_mask_next;
  logic [9:0]    visible_mask_next;
  logic [9:0]    urgent_mask_next;
  logic          blink_on_next;
  logic [15:0]   blink_count_next;
  logic [IW-1:0] scan_index_next;
  logic          show_commit;
  logic          digit_write;

  // Tick result
  logic [7:0] seg_next;
  logic [3:0] sel_next;
  logic       lit_next;

  logic          is_byte;
  logic          is_tick;
  logic          is_digit;
  logic [3:0]    byte_digit;
  logic [IW-1:0] cur_index;
  logic [CW-1:0] cur_index_ext;
  logic [CW-1:0] inc_index;
  logic [CW-1:0] pos;
  logic [3:0]    cur_digit;
  logic          dot;
  logic [15:0]   blink_inc;

  // Handshake: a byte always drains, a tick needs room in the result register
  assign s1_advance = s1_valid && ((s1_type == sevseg_pkg::REQ_BYTE) || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign is_byte    = s1_advance && (s1_type == sevseg_pkg::REQ_BYTE);
  assign is_tick    = s1_advance && (s1_type == sevseg_pkg::REQ_TICK);

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_show_char    <= sevseg_pkg::RST_SHOW_CHAR;
      cmd_visible_char <= sevseg_pkg::RST_VISIBLE_CHAR;
      cmd_urgent_char  <= sevseg_pkg::RST_URGENT_CHAR;
      blink_ticks      <= sevseg_pkg::RST_BLINK_TICKS;
    end else if (cfg_write) begin
      case (cfg_index)
        sevseg_pkg::CFG_SHOW_CHAR:    cmd_show_char    <= cfg_data[7:0];
        sevseg_pkg::CFG_VISIBLE_CHAR: cmd_visible_char <= cfg_data[7:0];
        sevseg_pkg::CFG_URGENT_CHAR:  cmd_urgent_char  <= cfg_data[7:0];
        sevseg_pkg::CFG_BLINK_TICKS:  blink_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture input transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_type <= req_type;
      s1_byte <= rx_byte;
    end
  end

  // Decode a byte
  assign is_digit   = (s1_byte >= sevseg_pkg::CHAR_ZERO) && (s1_byte <= sevseg_pkg::CHAR_NINE);
  assign byte_digit = s1_byte[3:0];

  // Pick the scanned digit and build its pattern
  assign cur_index     = ({{(CW - IW){1'b0}}, scan_index} >= shown_count) ? '0 : scan_index;
  assign cur_index_ext = {{(CW - IW){1'b0}}, cur_index};
  assign inc_index     = cur_index_ext + CW'(1);
  assign pos           = cur_index_ext + (DIGITS_CW - shown_count);
  assign cur_digit     = sevseg_pkg::digit_mod10(shown_digits[cur_index]);
  assign dot           = visible_mask[cur_digit] || (blink_on && urgent_mask[cur_digit]);
  assign blink_inc     = blink_count + 16'd1;

  always_comb begin
    seg_next = 8'h00;
    sel_next = 4'hF;
    lit_next = 1'b0;
    if (shown_count != '0) begin
      seg_next = sevseg_pkg::seg_pattern(cur_digit) | (dot ? sevseg_pkg::SEG_DP : 8'h00);
      for (int i = 0; i < 4; i++) begin
        if ({{(32 - CW){1'b0}}, pos} == 32'(i)) begin
          sel_next[i] = 1'b0;
        end
      end
      lit_next = 1'b1;
    end
  end

  // Next state for bytes and ticks
  always_comb begin
    shown_count_next   = shown_count;
    pending_count_next = pending_count;
    pending_mask_next  = pending_mask;
    visible_mask_next  = visible_mask;
    urgent_mask_next   = urgent_mask;
    blink_on_next      = blink_on;
    blink_count_next   = blink_count;
    scan_index_next    = scan_index;
    show_commit        = 1'b0;
    digit_write        = 1'b0;
    if (is_byte) begin
      if (s1_byte == cmd_show_char) begin
        show_commit        = 1'b1;
        shown_count_next   = pending_count;
        pending_count_next = '0;
        pending_mask_next  = '0;
      end else if (s1_byte == cmd_visible_char) begin
        visible_mask_next  = pending_mask;
        pending_count_next = '0;
        pending_mask_next  = '0;
      end else if (s1_byte == cmd_urgent_char) begin
        urgent_mask_next   = pending_mask;
        pending_count_next = '0;
        pending_mask_next  = '0;
      end else if (is_digit) begin
        if (pending_count < DIGITS_CW) begin
          digit_write        = 1'b1;
          pending_count_next = pending_count + CW'(1);
        end
        pending_mask_next = pending_mask | (10'd1 << byte_digit);
      end
    end
    if (is_tick) begin
      if (shown_count == '0) begin
        scan_index_next = '0;
      end else begin
        scan_index_next = (inc_index >= shown_count) ? '0 : inc_index[IW-1:0];
      end
      if (blink_inc >= blink_ticks) begin
        blink_count_next = '0;
        blink_on_next    = !blink_on;
      end else begin
        blink_count_next = blink_inc;
      end
    end
  end

  // Update display state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGITS; i++) begin
        shown_digits[i] <= 4'd8;
      end
      shown_count   <= DIGITS_CW;
      pending_count <= '0;
      pending_mask  <= '0;
      visible_mask  <= 10'h100;
      urgent_mask   <= '0;
      blink_on      <= 1'b0;
      blink_count   <= '0;
      scan_index    <= '0;
    end else begin
      if (show_commit) begin
        shown_digits <= pending_digits;
      end
      shown_count   <= shown_count_next;
      pending_count <= pending_count_next;
      pending_mask  <= pending_mask_next;
      visible_mask  <= visible_mask_next;
      urgent_mask   <= urgent_mask_next;
      blink_on      <= blink_on_next;
      blink_count   <= blink_count_next;
      scan_index    <= scan_index_next;
    end
  end

  // Store pending digits; entries above the fill count are never read
  always_ff @(posedge clk) begin
    if (digit_write) begin
      pending_digits[pending_count[IW-1:0]] <= byte_digit;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      segment_lines  <= seg_next;
      digit_select_n <= sel_next;
      lit            <= lit_next;
    end
  end

endmodule

// ----- rtl/sevseg_checker.sv -----
`include "serial_seven_segment_scanner_unit_defines.svh"

module sevseg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  segment_lines,
  input logic [3:0]  digit_select_n,
  input logic        lit
);

  // A stalled result holds
  `SEVSEG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(segment_lines) && $stable(digit_select_n) && $stable(lit), "result changed while stalled")

  // A blank result drives nothing
  `SEVSEG_ASSERT(a_blank, out_valid && !lit |-> segment_lines == 8'h00 && digit_select_n == 4'hF, "blank result drives segments or a digit")

  // A lit result always shows a digit pattern
  `SEVSEG_ASSERT(a_lit_pattern, out_valid && lit |-> segment_lines[7:2] != 6'd0, "lit result has no digit segments")

  // A tick transfer into an idle block yields a result after the input and result registers
  `SEVSEG_ASSERT(a_tick_result, in_valid && in_ready && req_type == sevseg_pkg::REQ_TICK && !out_valid |=> ##1 out_valid, "tick gave no result")

  // Reset empties the result register
  `SEVSEG_ASSERT_RST(a_reset, rst |=> !out_valid, "result pending after reset")

endmodule

bind serial_seven_segment_scanner_unit sevseg_checker u_sevseg_checker (.*);
